>>> hw/rtl/dilvi_pkg.sv
package dilvi_pkg;

    localparam int SPEED_NODES = 3;
    localparam int VOTE_CH     = 7;
    localparam int Q_DEPTH     = 2;

    localparam logic [10:0] CLASS_MASK  = 11'h780;
    localparam logic [10:0] CLASS_SPEED = 11'h280;
    localparam logic [10:0] CLASS_IO_A  = 11'h380;
    localparam logic [10:0] CLASS_IO_B  = 11'h480;
    localparam logic [2:0]  NODE_IO_B   = 3'h7;
    localparam logic [14:0] LIMIT_RESET = 15'd500;
    localparam logic [14:0] MAG_MAX     = 15'h7FFF;

    localparam logic [7:0] WR_MASK_NONE  = 8'h00;
    localparam logic [7:0] WR_MASK_SPEED = 8'h20;
    localparam logic [7:0] WR_MASK_EVAL  = 8'h1E;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_SPEED,
        CMD_IO_A,
        CMD_IO_B,
        CMD_EVAL
    } t_cmd_kind;

    // decoded request handed from front to back; li/fb/bits already active-high
    typedef struct packed {
        t_cmd_kind   kind;
        logic [1:0]  node;
        logic [14:0] mag;
        logic [3:0]  bits;
        logic [7:0]  li;
        logic [7:0]  fb;
    } t_cmd;

endpackage

>>> hw/rtl/dilvi_in_if.sv
interface dilvi_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [10:0] frame_id;
    logic [7:0]  data_byte0;
    logic [7:0]  data_byte2;
    logic [7:0]  data_byte3;
    logic [7:0]  local_inputs;
    logic [7:0]  output_feedback;

    modport source (output valid, output operation, output frame_id, output data_byte0,
                    output data_byte2, output data_byte3, output local_inputs,
                    output output_feedback, input ready);
    modport sink (input valid, input operation, input frame_id, input data_byte0,
                  input data_byte2, input data_byte3, input local_inputs,
                  input output_feedback, output ready);
endinterface

>>> hw/rtl/dilvi_out_if.sv
interface dilvi_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] write_mask;
    logic [7:0] write_value;

    modport source (output valid, output write_mask, output write_value, input ready);
    modport sink (input valid, input write_mask, input write_value, output ready);
endinterface

>>> hw/rtl/dilvi_cfg_if.sv
interface dilvi_cfg_if;
    logic        valid;
    logic        ready;
    logic [14:0] slow_speed_limit;

    modport source (output valid, output slow_speed_limit, input ready);
    modport sink (input valid, input slow_speed_limit, output ready);
endinterface

>>> hw/rtl/dilvi_front.sv
module dilvi_front (
    dilvi_in_if.sink        i_in,
    input  logic            i_q_ready,
    output logic            o_q_push,
    output dilvi_pkg::t_cmd o_cmd
);
    import dilvi_pkg::*;

    logic [10:0] cls;
    logic [15:0] raw;
    logic [15:0] neg;
    logic [7:0]  d0;

    assign i_in.ready = i_q_ready;
    assign o_q_push   = i_in.valid & i_q_ready;

    always_comb begin
        cls = i_in.frame_id & CLASS_MASK;
        raw = {i_in.data_byte3, i_in.data_byte2};
        neg = 16'd0 - raw;
        d0  = ~i_in.data_byte0;

        o_cmd.kind = CMD_NONE;
        o_cmd.node = i_in.frame_id[1:0];
        o_cmd.bits = 4'd0;
        o_cmd.li   = ~i_in.local_inputs;
        o_cmd.fb   = ~i_in.output_feedback;
        // -32768 has no positive twin; clamp
        if (raw[15]) begin
            o_cmd.mag = neg[15] ? MAG_MAX : neg[14:0];
        end else begin
            o_cmd.mag = raw[14:0];
        end

        if (i_in.operation) begin
            o_cmd.kind = CMD_EVAL;
        end else if (cls == CLASS_SPEED) begin
            o_cmd.kind = CMD_SPEED;
        end else if (cls == CLASS_IO_A) begin
            o_cmd.kind = CMD_IO_A;
            o_cmd.bits = {d0[4], d0[3], d0[1], d0[0]};
        end else if (cls == CLASS_IO_B && i_in.frame_id[2:0] == NODE_IO_B) begin
            o_cmd.kind = CMD_IO_B;
            o_cmd.bits = {1'b0, d0[2:0]};
        end
    end
endmodule

>>> hw/rtl/dilvi_queue.sv
module dilvi_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dilvi_pkg::t_cmd i_cmd,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output dilvi_pkg::t_cmd o_cmd
);
    import dilvi_pkg::*;

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(Q_DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(Q_DEPTH - 1);

    t_cmd          r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_ready = (r_cnt != CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push & o_ready;
    assign do_pop  = i_pop & o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end
endmodule

>>> hw/rtl/dilvi_back.sv
module dilvi_back #(
    parameter int P_SPEED_NODES = dilvi_pkg::SPEED_NODES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  dilvi_pkg::t_cmd i_cmd,
    output logic            o_q_pop,
    dilvi_cfg_if.sink       i_cfg,
    dilvi_out_if.source     o_out
);
    import dilvi_pkg::*;

    localparam int SW = (P_SPEED_NODES > 1) ? $clog2(P_SPEED_NODES) : 1;
    localparam int NW = $clog2(P_SPEED_NODES + 1);
    localparam logic [NW-1:0] SLOW_MIN = NW'(2);

    logic [14:0] r_limit;
    logic [14:0] r_mag [P_SPEED_NODES];
    logic [14:0] n_mag [P_SPEED_NODES];
    logic        r_over, n_over;
    logic [2:0]  r_hist [VOTE_CH];
    logic [2:0]  n_hist [VOTE_CH];
    logic [VOTE_CH-1:0] voted;
    logic        r_out_valid;
    logic [7:0]  r_mask, r_val, n_mask, n_val;
    logic [NW-1:0] slow;
    logic [SW-1:0] slot;
    logic [2:0]  hn;

    logic vsl, vsp, r1, r2, tp, vbtrk, skark, idle;
    logic pon, pov, skarv, skarn, pusk, rkzd, vfb, nfb;
    logic fwd, rev, rzd, rtr;

    assign i_cfg.ready = 1'b1;
    assign o_q_pop     = i_q_valid & (~r_out_valid | o_out.ready);
    assign o_out.valid       = r_out_valid;
    assign o_out.write_mask  = r_mask;
    assign o_out.write_value = r_val;

    always_comb begin
        for (int k = 0; k < VOTE_CH; k++) begin
            voted[k] = (r_hist[k][0] & r_hist[k][1]) | (r_hist[k][0] & r_hist[k][2]) |
                       (r_hist[k][1] & r_hist[k][2]);
        end
    end

    assign vsl   = voted[0];
    assign vsp   = voted[1];
    assign r1    = voted[2];
    assign r2    = voted[3];
    assign tp    = voted[4];
    assign vbtrk = voted[5];
    assign skark = voted[6];
    assign idle  = ~r1 & ~r2;
    assign pon   = i_cmd.li[0];
    assign pov   = i_cmd.li[1];
    assign skarv = i_cmd.li[2];
    assign skarn = i_cmd.li[3];
    assign pusk  = i_cmd.li[4];
    assign rkzd  = i_cmd.li[6];
    assign vfb   = i_cmd.fb[1];
    assign nfb   = i_cmd.fb[2];

    always_comb begin
        fwd = ~nfb & pov & (vsl | idle) &
              ((skarv & ~r1) | (r1 & ~r2 & (vfb | (pusk & ~vsp)))) & tp;
        rev = ~fwd & pon & (vsp | idle) &
              ((skarn & ~r1) | (r1 & ~r2 & (nfb | (pusk & ~vsl)))) & tp;
        rzd = (fwd | rev) & ((~r1 & r2) | (rkzd & vbtrk & skark)) & tp;
        rtr = ((rzd & (fwd | rev)) | (vsl & vsp & r_over)) & tp;
    end

    always_comb begin
        slot = SW'(i_cmd.node - 2'd1);
        for (int i = 0; i < P_SPEED_NODES; i++) begin
            n_mag[i] = r_mag[i];
        end
        // node 0 stores nothing but still refreshes the flag
        if (i_cmd.kind == CMD_SPEED && i_cmd.node != 2'd0 &&
            32'(i_cmd.node) <= P_SPEED_NODES) begin
            n_mag[slot] = i_cmd.mag;
        end
        slow = '0;
        for (int i = 0; i < P_SPEED_NODES; i++) begin
            slow = slow + NW'(n_mag[i] <= r_limit);
        end
    end

    always_comb begin
        n_over = r_over;
        n_mask = WR_MASK_NONE;
        n_val  = 8'h00;
        for (int k = 0; k < VOTE_CH; k++) begin
            n_hist[k] = r_hist[k];
        end
        hn = 3'd0;
        case (i_cmd.kind)
            CMD_EVAL: begin
                n_mask = WR_MASK_EVAL;
                n_val  = {3'b000, rtr, rzd, rev, fwd, 1'b0};
            end
            CMD_SPEED: begin
                n_over = (slow < SLOW_MIN);
                n_mask = WR_MASK_SPEED;
                n_val  = n_over ? WR_MASK_SPEED : 8'h00;
            end
            CMD_IO_A: begin
                for (int k = 0; k < 4; k++) begin
                    hn = r_hist[k];
                    n_hist[k] = {hn[1:0], i_cmd.bits[k]};
                end
            end
            CMD_IO_B: begin
                for (int k = 0; k < 3; k++) begin
                    hn = r_hist[k + 4];
                    n_hist[k + 4] = {hn[1:0], i_cmd.bits[k]};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_RESET;
            r_over      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < P_SPEED_NODES; i++) begin
                r_mag[i] <= '0;
            end
            for (int k = 0; k < VOTE_CH; k++) begin
                r_hist[k] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                r_limit <= i_cfg.slow_speed_limit;
            end
            if (o_q_pop) begin
                r_over      <= n_over;
                r_out_valid <= 1'b1;
                for (int i = 0; i < P_SPEED_NODES; i++) begin
                    r_mag[i] <= n_mag[i];
                end
                for (int k = 0; k < VOTE_CH; k++) begin
                    r_hist[k] <= n_hist[k];
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_mask <= n_mask;
            r_val  <= n_val;
        end
    end
endmodule

>>> hw/rtl/drive_interlock_with_voted_inputs_top.sv
// Drive interlock with voted inputs.
// i_in carries one request per item: a received bus frame (operation 0) or an
// interlock evaluation (operation 1). Every request yields exactly one
// mask/value output write on o_out, in request order. i_cfg writes the slow
// speed limit; it is always ready and should only be written while idle.
// Front decodes the frame class and speed magnitude, a two-entry queue
// follows, and the back end updates speeds, overspeed flag and vote histories
// and evaluates the interlock equations into an output register.
// A request passes through the queue and then the output register before its
// write shows on o_out. Throughput: one request per cycle, sustained, while
// o_out is ready.
// If o_out stalls, the output register holds, the queue fills (two entries)
// and i_in.ready drops; nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous) clears speeds, flag, histories, queue and
// output valid, and loads the limit with 500.
module drive_interlock_with_voted_inputs_top #(
    parameter int P_SPEED_NODES = dilvi_pkg::SPEED_NODES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dilvi_in_if.sink    i_in,
    dilvi_cfg_if.sink   i_cfg,
    dilvi_out_if.source o_out
);
    import dilvi_pkg::*;

    t_cmd front_cmd;
    t_cmd q_cmd;
    logic q_ready, q_push, q_valid, q_pop;

    dilvi_front u_front (
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_q_push  (q_push),
        .o_cmd     (front_cmd)
    );

    dilvi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    dilvi_back #(
        .P_SPEED_NODES (P_SPEED_NODES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .o_q_pop   (q_pop),
        .i_cfg     (i_cfg),
        .o_out     (o_out)
    );
endmodule
